[rtl/equal_share_audio_mixer_macros.svh]
// ----------------------------------------------------------------------------
// Equal-share audio mixer assertion macros
// Shared helpers for the concurrent checks on the mixer's ports.
// ----------------------------------------------------------------------------
`ifndef EQUAL_SHARE_AUDIO_MIXER_MACROS_SVH
`define EQUAL_SHARE_AUDIO_MIXER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while reset is low.
`define ESAM_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("equal_share_audio_mixer: port check failed");

// Next-cycle implication, sampled on the rising clock, off while reset is low.
`define ESAM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("equal_share_audio_mixer: port check failed");

`endif

[rtl/esam_pkg.sv]
// ----------------------------------------------------------------------------
// esam_pkg
// Types, codes and constants shared by the equal-share audio mixer modules.
// ----------------------------------------------------------------------------
package esam_pkg;

    // Default sizing of the participant table and the frame buffer.
    localparam int ESAM_MAX_SLOTS = 128;
    localparam int ESAM_FRAME_LEN = 1024;

    // Field widths of the request and result channels.
    localparam int OP_W     = 2;
    localparam int CH_W     = 7;
    localparam int POS_IN_W = 10;
    localparam int SAMPLE_W = 8;
    localparam int STATUS_W = 2;

    // Divider width and the fixed-point scale of the reciprocal.
    localparam int DIV_W       = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_ONE   = 1 << RECIP_SHIFT;
    localparam int PROD_W      = SAMPLE_W + DIV_W;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INACTIVE = 2'd2;

    // Request opcodes.
    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_JOIN  = 2'd1,
        OP_LEAVE = 2'd2,
        OP_NONE  = 2'd3
    } esam_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic decode;
        logic div_start;
        logic pos_load;
        logic store;
        logic recip_load;
        logic walk_issue;
        logic clear_start;
        logic clear_step;
        logic join_commit;
        logic leave_commit;
        logic load_out;
    } esam_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        esam_op_t op;
        logic     write_live;
        logic     join_ok;
        logic     leave_live;
        logic     div_done;
        logic     walk_last;
        logic     clear_last;
        logic     pipe_busy;
    } esam_sts_t;

endpackage

[rtl/equal_share_audio_mixer.sv]
// ----------------------------------------------------------------------------
// equal_share_audio_mixer
// Mixes signed 8-bit audio from participant slots with equal gain.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_valid/s_ready with s_op, s_channel, s_position and
//   s_sample; each request gives exactly one result on m_valid/m_ready with
//   m_mixed, m_slot and m_status. One request is worked on at a time.
//   A write reduces the position modulo FRAME_LEN, stores the sample, takes
//   the reciprocal of the active count from the serial divider, then walks
//   slots 0 to next_free_slot - 1 one per cycle through the memory read
//   port and drains the read, multiply and accumulate pipeline before the
//   result is loaded. A join clears the new slot's frame buffer one sample
//   per cycle before its result is loaded; a leave or a rejected request
//   goes from decode to its result. The next request can be taken once
//   the result is loaded and the controller is idle again.
//   Reset (aresetn low, synchronous) empties the slot table and drops any
//   pending result; there is no clearing pass, since every slot's buffer is
//   cleared when it is joined. s_ready is high only between requests; a
//   new request may be taken while the last result still waits, and a
//   stalled m_ready holds the finished result and the controller in place.
// ----------------------------------------------------------------------------
module equal_share_audio_mixer #(
    parameter int MAX_SLOTS = esam_pkg::ESAM_MAX_SLOTS,
    parameter int FRAME_LEN = esam_pkg::ESAM_FRAME_LEN
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [esam_pkg::OP_W-1:0]            s_op,
    input  logic [esam_pkg::CH_W-1:0]            s_channel,
    input  logic [esam_pkg::POS_IN_W-1:0]        s_position,
    input  logic signed [esam_pkg::SAMPLE_W-1:0] s_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [esam_pkg::SAMPLE_W-1:0] m_mixed,
    output logic [esam_pkg::CH_W-1:0]            m_slot,
    output logic [esam_pkg::STATUS_W-1:0]        m_status
);
    import esam_pkg::*;

    esam_cmd_t cmd;
    esam_sts_t sts;

    // Request sequencing and handshakes.
    esam_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Storage, arithmetic and result registers.
    esam_dp #(
        .MAX_SLOTS (MAX_SLOTS),
        .FRAME_LEN (FRAME_LEN)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .in_op       (s_op),
        .in_channel  (s_channel),
        .in_position (s_position),
        .in_sample   (s_sample),
        .out_mixed   (m_mixed),
        .out_slot    (m_slot),
        .out_status  (m_status)
    );

endmodule

[rtl/esam_div.sv]
// ----------------------------------------------------------------------------
// esam_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module esam_div #(
    parameter int W = esam_pkg::DIV_W
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);
    import esam_pkg::*;

    localparam int CNT_W = $clog2(W);

    logic         busy_reg;
    logic         done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0] q_reg;
    logic [W-1:0] r_reg;
    logic [W-1:0] d_reg;

    logic [W:0]   trial;
    logic [W:0]   diff;
    logic         fits;

    // One shift-and-subtract step of the partial remainder.
    always_comb begin
        trial = {r_reg, q_reg[W-1]};
        diff  = trial - {1'b0, d_reg};
        fits  = trial >= {1'b0, d_reg};
    end

    // Control of the iteration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Quotient and remainder registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else if (busy_reg) begin
            q_reg <= {q_reg[W-2:0], fits};
            r_reg <= fits ? diff[W-1:0] : trial[W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

[rtl/esam_dp.sv]
// ----------------------------------------------------------------------------
// esam_dp
// Mixer datapath: sample memory, slot table, divider, scaling pipeline and
// the result registers.
// ----------------------------------------------------------------------------
module esam_dp #(
    parameter int MAX_SLOTS = esam_pkg::ESAM_MAX_SLOTS,
    parameter int FRAME_LEN = esam_pkg::ESAM_FRAME_LEN
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  esam_pkg::esam_cmd_t                    cmd,
    output esam_pkg::esam_sts_t                    sts,
    input  logic [esam_pkg::OP_W-1:0]              in_op,
    input  logic [esam_pkg::CH_W-1:0]              in_channel,
    input  logic [esam_pkg::POS_IN_W-1:0]          in_position,
    input  logic signed [esam_pkg::SAMPLE_W-1:0]   in_sample,
    output logic signed [esam_pkg::SAMPLE_W-1:0]   out_mixed,
    output logic [esam_pkg::CH_W-1:0]              out_slot,
    output logic [esam_pkg::STATUS_W-1:0]          out_status
);
    import esam_pkg::*;

    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int POS_W     = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
    localparam int EXT_W     = CNT_W + CH_W;
    localparam int ADDR_W    = SLOT_W + POS_W;
    localparam int MEM_DEPTH = MAX_SLOTS * (2 ** POS_W);

    // Fixed-point reciprocal of the frame length; exact for every 10-bit
    // position, and the quotient is zero whenever the frame is longer.
    localparam int PQ_SHIFT  = 2 * POS_IN_W;
    localparam int PQ_RECIP  = ((1 << PQ_SHIFT) + FRAME_LEN - 1) / FRAME_LEN;
    localparam int PQ_PROD_W = POS_IN_W + PQ_SHIFT + 1;

    // Captured request.
    esam_op_t                  op_reg;
    logic [CH_W-1:0]           ch_reg;
    logic [POS_IN_W-1:0]       pos_reg;
    logic [SAMPLE_W-1:0]       sample_reg;

    // Participant table.
    logic [MAX_SLOTS-1:0]      slot_active_reg;
    logic [CNT_W-1:0]          next_free_reg;
    logic [CNT_W-1:0]          count_reg;

    // Working registers.
    logic [POS_IN_W-1:0]       pos_quot_reg;
    logic [POS_W-1:0]          pos_mod_reg;
    logic [DIV_W-1:0]          recip_reg;
    logic [CNT_W-1:0]          walk_cnt_reg;
    logic [POS_W-1:0]          clr_cnt_reg;
    logic [SAMPLE_W-1:0]       rd_data_reg;
    logic                      va_reg;
    logic                      vb_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic                      neg_reg;
    logic [SAMPLE_W-1:0]       acc_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic [CH_W-1:0]           slot_reg;

    // Result registers.
    logic [SAMPLE_W-1:0]       m_mixed_reg;
    logic [CH_W-1:0]           m_slot_reg;
    logic [STATUS_W-1:0]       m_status_reg;

    // Sample memory, one frame buffer per slot.
    logic [SAMPLE_W-1:0]       mem [MEM_DEPTH];

    logic [EXT_W-1:0]          ch_ext;
    logic [EXT_W-1:0]          nf_ext;
    logic [SLOT_W-1:0]         ch_idx;
    logic [SLOT_W-1:0]         nf_idx;
    logic [SLOT_W-1:0]         walk_idx;
    logic                      ch_live;
    logic                      write_live;
    logic                      join_ok;
    logic [STATUS_W-1:0]       status_next;
    logic [ADDR_W-1:0]         wr_addr;
    logic [ADDR_W-1:0]         rd_addr;
    logic [PQ_PROD_W-1:0]      pos_prod;
    logic [PQ_PROD_W-1:0]      pos_rem;
    logic [DIV_W-1:0]          div_a;
    logic [DIV_W-1:0]          div_b;
    logic                      div_done;
    logic [DIV_W-1:0]          div_q;
    logic [SAMPLE_W-1:0]       mag;
    logic [SAMPLE_W-1:0]       q_mag;
    logic [SAMPLE_W-1:0]       q_val;

    // Slot lookups and request checks.
    always_comb begin
        ch_ext     = EXT_W'(ch_reg);
        nf_ext     = EXT_W'(next_free_reg);
        ch_idx     = ch_ext[SLOT_W-1:0];
        nf_idx     = next_free_reg[SLOT_W-1:0];
        walk_idx   = walk_cnt_reg[SLOT_W-1:0];
        ch_live    = (ch_ext < EXT_W'(MAX_SLOTS)) && slot_active_reg[ch_idx];
        write_live = ch_live && (count_reg != '0);
        join_ok    = next_free_reg < CNT_W'(MAX_SLOTS);
    end

    // Status code of the captured request, taken before any table update.
    always_comb begin
        case (op_reg)
            OP_WRITE: status_next = write_live ? ST_OK : ST_INACTIVE;
            OP_JOIN:  status_next = join_ok ? ST_OK : ST_FULL;
            OP_LEAVE: status_next = ch_live ? ST_OK : ST_INACTIVE;
            default:  status_next = ST_OK;
        endcase
    end

    // Position modulo the frame length: the quotient comes from the constant
    // reciprocal, the remainder from one multiply-subtract on the registered quotient.
    always_comb begin
        pos_prod = PQ_PROD_W'(pos_reg) * PQ_PROD_W'(PQ_RECIP);
        pos_rem  = PQ_PROD_W'(pos_reg) - PQ_PROD_W'(pos_quot_reg) * PQ_PROD_W'(FRAME_LEN);
    end

    // Divider operands: the reciprocal ceil(2^16 / active count).
    always_comb begin
        div_a = DIV_W'(RECIP_ONE) + DIV_W'(count_reg) - DIV_W'(1);
        div_b = DIV_W'(count_reg);
    end

    esam_div #(
        .W(DIV_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q)
    );

    // Captured request, working and result registers without reset.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= esam_op_t'(in_op);
            ch_reg     <= in_channel;
            pos_reg    <= in_position;
            sample_reg <= in_sample;
        end
        if (cmd.decode) begin
            status_reg   <= status_next;
            slot_reg     <= (op_reg == OP_JOIN && join_ok) ? nf_ext[CH_W-1:0] : '0;
            pos_quot_reg <= pos_prod[PQ_SHIFT +: POS_IN_W];
            walk_cnt_reg <= '0;
        end else if (cmd.walk_issue) begin
            walk_cnt_reg <= walk_cnt_reg + CNT_W'(1);
        end
        if (cmd.clear_start) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_step) begin
            clr_cnt_reg <= clr_cnt_reg + POS_W'(1);
        end
        if (cmd.pos_load) begin
            pos_mod_reg <= pos_rem[POS_W-1:0];
        end
        if (cmd.recip_load) begin
            recip_reg <= div_q;
        end
        if (cmd.load_out) begin
            m_mixed_reg  <= acc_reg;
            m_slot_reg   <= slot_reg;
            m_status_reg <= status_reg;
        end
    end

    // Slot table updates on join and leave.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_active_reg <= '0;
            next_free_reg   <= '0;
            count_reg       <= '0;
        end else if (cmd.join_commit) begin
            slot_active_reg[nf_idx] <= 1'b1;
            next_free_reg           <= next_free_reg + CNT_W'(1);
            count_reg               <= count_reg + CNT_W'(1);
        end else if (cmd.leave_commit) begin
            slot_active_reg[ch_idx] <= 1'b0;
            if (count_reg != '0) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Memory addresses: the request's own sample, the buffer being cleared,
    // and the slot under the walk.
    always_comb begin
        wr_addr = cmd.store ? {ch_idx, pos_mod_reg} : {nf_idx, clr_cnt_reg};
        rd_addr = {walk_idx, pos_mod_reg};
    end

    // Sample memory with one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            mem[wr_addr] <= sample_reg;
        end else if (cmd.clear_step) begin
            mem[wr_addr] <= '0;
        end
        if (cmd.walk_issue) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Magnitude of the read sample and the truncated quotient.
    always_comb begin
        mag   = rd_data_reg[SAMPLE_W-1] ? (~rd_data_reg + SAMPLE_W'(1)) : rd_data_reg;
        q_mag = prod_reg[RECIP_SHIFT +: SAMPLE_W];
        q_val = neg_reg ? (SAMPLE_W'(0) - q_mag) : q_mag;
    end

    // Scaling pipeline valid bits of the read and multiply stages, which feed the accumulate.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            va_reg <= cmd.walk_issue && slot_active_reg[walk_idx];
            vb_reg <= va_reg;
        end
    end

    // Multiply by the reciprocal, then add the wrapped quotient.
    always_ff @(posedge aclk) begin
        if (va_reg) begin
            prod_reg <= PROD_W'(mag) * PROD_W'(recip_reg);
            neg_reg  <= rd_data_reg[SAMPLE_W-1];
        end
        if (cmd.capture) begin
            acc_reg <= '0;
        end else if (vb_reg) begin
            acc_reg <= acc_reg + q_val;
        end
    end

    // Status to the controller.
    always_comb begin
        sts.op         = op_reg;
        sts.write_live = write_live;
        sts.join_ok    = join_ok;
        sts.leave_live = ch_live;
        sts.div_done   = div_done;
        sts.walk_last  = walk_cnt_reg == (next_free_reg - CNT_W'(1));
        sts.clear_last = clr_cnt_reg == POS_W'(FRAME_LEN - 1);
        sts.pipe_busy  = va_reg || vb_reg;
    end

    assign out_mixed  = m_mixed_reg;
    assign out_slot   = m_slot_reg;
    assign out_status = m_status_reg;

endmodule

[rtl/esam_ctrl.sv]
// ----------------------------------------------------------------------------
// esam_ctrl
// Mixer controller: sequences each request through the datapath and owns
// the request and result handshakes.
// ----------------------------------------------------------------------------
module esam_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output esam_pkg::esam_cmd_t cmd,
    input  esam_pkg::esam_sts_t sts
);
    import esam_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POS_DIV,
        S_STORE,
        S_RECIP_DIV,
        S_WALK,
        S_DRAIN,
        S_CLEAR,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.decode = 1'b1;
                state_next = S_FINISH;
                case (sts.op)
                    OP_WRITE: begin
                        if (sts.write_live) begin
                            state_next = S_POS_DIV;
                        end
                    end
                    OP_JOIN: begin
                        if (sts.join_ok) begin
                            cmd.clear_start = 1'b1;
                            state_next      = S_CLEAR;
                        end
                    end
                    OP_LEAVE: begin
                        cmd.leave_commit = sts.leave_live;
                    end
                    default: begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_POS_DIV: begin
                cmd.pos_load = 1'b1;
                state_next   = S_STORE;
            end
            S_STORE: begin
                cmd.store     = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_RECIP_DIV;
            end
            S_RECIP_DIV: begin
                if (sts.div_done) begin
                    cmd.recip_load = 1'b1;
                    state_next     = S_WALK;
                end
            end
            S_WALK: begin
                cmd.walk_issue = 1'b1;
                if (sts.walk_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!sts.pipe_busy) begin
                    state_next = S_FINISH;
                end
            end
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last) begin
                    cmd.join_commit = 1'b1;
                    state_next      = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result valid: set when a result is loaded, dropped once it is taken.
    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;

endmodule

[rtl/esam_checker.sv]
// ----------------------------------------------------------------------------
// esam_checker
// Port-level checks of the mixer's results, bound to the top level.
// ----------------------------------------------------------------------------
`include "equal_share_audio_mixer_macros.svh"

module esam_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [esam_pkg::SAMPLE_W-1:0] m_mixed,
    input logic [esam_pkg::CH_W-1:0]            m_slot,
    input logic [esam_pkg::STATUS_W-1:0]        m_status
);
    import esam_pkg::*;

    // A rejected request never carries a mixed sample.
    `ESAM_ASSERT_IMPL(a_reject_no_mix, aclk, aresetn, m_valid && m_status != ST_OK, m_mixed == '0)

    // A full table never hands out a slot.
    `ESAM_ASSERT_IMPL(a_full_no_slot, aclk, aresetn, m_valid && m_status == ST_FULL, m_slot == '0)

    // A join result with a nonzero slot carries no mixed sample and an OK status.
    `ESAM_ASSERT_IMPL(a_slot_no_mix, aclk, aresetn, m_valid && m_slot != '0, m_mixed == '0 && m_status == ST_OK)

    // A stalled result holds.
    `ESAM_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_mixed) && $stable(m_slot) && $stable(m_status))

endmodule

bind equal_share_audio_mixer esam_checker u_esam_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_mixed  (m_mixed),
    .m_slot   (m_slot),
    .m_status (m_status)
);
